### rtl/lba_pkg.sv
// package: request codes, status codes and the link table port type
package lba_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-3:0] REG_BLOCKS_IN_USE = 1'b0;

    localparam logic [2:0] F_FORMAT = 3'd0;
    localparam logic [2:0] F_ALLOC  = 3'd1;
    localparam logic [2:0] F_FREE   = 3'd2;
    localparam logic [2:0] F_READ   = 3'd3;
    localparam logic [2:0] F_WRITE  = 3'd4;
    localparam logic [2:0] F_COUNT  = 3'd5;

    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_EMPTY = 2'd1;
    localparam logic [1:0] STS_LOOP  = 2'd2;
    localparam logic [1:0] STS_RANGE = 2'd3;

    typedef struct packed {
        logic       rd_en;
        logic [7:0] rd_addr;
        logic       wr_en;
        logic [7:0] wr_addr;
        logic [7:0] wr_data;
    } t_mem_req;

endpackage

### rtl/lba_if.sv
// request and response channel interfaces
interface lba_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] func;
    logic [7:0] block;
    logic [7:0] link_value;

    modport source (output valid, func, block, link_value, input ready);
    modport sink (input valid, func, block, link_value, output ready);
endinterface

interface lba_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  block_out;
    logic [11:0] free_bytes;
    logic [1:0]  status;

    modport source (output valid, block_out, free_bytes, status, input ready);
    modport sink (input valid, block_out, free_bytes, status, output ready);
endinterface

### rtl/lba_link_mem.sv
// next-block link table: one write and one registered read per cycle
module lba_link_mem
    import lba_pkg::*;
#(
    parameter int NUM_BLOCKS = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_mem_req   i_req,
    output logic [7:0] o_link
);
    localparam int AW = $clog2(NUM_BLOCKS);

    logic [7:0] mem [NUM_BLOCKS];
    logic [7:0] r_rdata;
    logic       r_rd_ok;
    logic       wr_ok;
    logic       rd_ok;

    // links beyond the store read as end of chain and drop writes
    assign wr_ok = {1'b0, i_req.wr_addr} < 9'(NUM_BLOCKS);
    assign rd_ok = {1'b0, i_req.rd_addr} < 9'(NUM_BLOCKS);

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en && wr_ok) begin
            mem[i_req.wr_addr[AW-1:0]] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rdata <= mem[i_req.rd_addr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ok <= 1'b0;
        end else if (i_req.rd_en) begin
            r_rd_ok <= rd_ok;
        end
    end

    assign o_link = r_rd_ok ? r_rdata : 8'd0;

endmodule

### rtl/linked_block_allocator.sv
// linked block allocator: free list over a next-block link table
//
// One request channel (func, block, link_value) and one response channel
// (block_out, free_bytes, status), both valid/ready; a word is taken when
// valid and ready are high at a clock edge. Exactly one response word
// follows every request word, in order. blocks_in_use sits at APB byte
// address 0 and must be written only while the block is idle; the block itself does not enforce this.
// A request is taken only while the sequencer is idle. Work per request,
// n being blocks_in_use clamped to FIRST_BLOCK+1..NUM_BLOCKS:
//   alloc, read link: table read, then write back and answer
//   write link, rejected requests, unused codes, count of an empty list: answered on acceptance
//   format: one table write per block, FIRST_BLOCK to n - 1
//   free: one table read per link followed, ending in the splice write or a loop report
//   count: one table read per block counted, up to n blocks
// The table read port feeds the next read address directly. A finished
// response lands in the output register; if that is still full a holding
// register keeps it, so the receiver may stall without losing words.
// Reset empties the free list (head 0) and sets blocks_in_use to 256; the
// link table is not cleared and must be formatted before use.
module linked_block_allocator
    import lba_pkg::*;
#(
    parameter int NUM_BLOCKS  = 256,
    parameter int FIRST_BLOCK = 4,
    parameter int BLOCK_BYTES = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    lba_req_if.sink               i_req,
    lba_rsp_if.source             o_rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_FMT  = 2'd1;
    localparam logic [1:0] S_WALK = 2'd2;
    localparam logic [1:0] S_HOLD = 2'd3;

    logic [1:0]  r_state, n_state;
    logic [7:0]  r_head, n_head;
    logic [7:0]  r_cur, n_cur;
    logic [9:0]  r_steps, n_steps;
    logic [7:0]  r_idx, n_idx;
    logic [2:0]  r_func, n_func;
    logic [7:0]  r_blk, n_blk;
    logic [8:0]  r_biu;

    logic        r_out_valid;
    logic [7:0]  r_out_bout;
    logic [11:0] r_out_bytes;
    logic [1:0]  r_out_status;
    logic [7:0]  r_hold_bout;
    logic [11:0] r_hold_bytes;
    logic [1:0]  r_hold_status;

    logic        fin_valid;
    logic [7:0]  fin_bout;
    logic [11:0] fin_bytes;
    logic [1:0]  fin_status;

    t_mem_req    mem_req;
    logic [7:0]  link;
    logic [8:0]  eff_cnt;
    logic        blk_ok;
    logic        req_acc;
    logic        slot_free;
    logic        cfg_wr;
    logic [9:0]  steps_inc;
    logic [15:0] prod;
    logic        fmt_last;

    lba_link_mem #(
        .NUM_BLOCKS(NUM_BLOCKS)
    ) u_mem (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (mem_req),
        .o_link (link)
    );

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[CFG_ADDR_W-1:2] == REG_BLOCKS_IN_USE) ? {23'd0, r_biu} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_biu <= 9'd256;
        end else if (cfg_wr && paddr[CFG_ADDR_W-1:2] == REG_BLOCKS_IN_USE) begin
            r_biu <= pwdata[8:0];
        end
    end

    // block count clamped to the usable range
    always_comb begin
        if (r_biu > 9'(NUM_BLOCKS)) begin
            eff_cnt = 9'(NUM_BLOCKS);
        end else if (r_biu < 9'(FIRST_BLOCK + 1)) begin
            eff_cnt = 9'(FIRST_BLOCK + 1);
        end else begin
            eff_cnt = r_biu;
        end
    end

    assign blk_ok    = (i_req.block >= 8'(FIRST_BLOCK)) && ({1'b0, i_req.block} < eff_cnt);
    assign req_acc   = i_req.valid && i_req.ready;
    assign slot_free = !r_out_valid || o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE);

    assign steps_inc = r_steps + 10'd1;
    assign prod      = 16'(steps_inc) * 16'(BLOCK_BYTES - 1);
    assign fmt_last  = ({1'b0, r_idx} + 9'd1) == eff_cnt;

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_cur      = r_cur;
        n_steps    = r_steps;
        n_idx      = r_idx;
        n_func     = r_func;
        n_blk      = r_blk;
        mem_req    = '0;
        fin_valid  = 1'b0;
        fin_bout   = 8'd0;
        fin_bytes  = 12'd0;
        fin_status = STS_OK;
        case (r_state)
            S_IDLE: begin
                if (req_acc) begin
                    n_func  = i_req.func;
                    n_blk   = i_req.block;
                    n_steps = 10'd0;
                    case (i_req.func)
                        F_FORMAT: begin
                            n_idx   = 8'(FIRST_BLOCK);
                            n_state = S_FMT;
                        end
                        F_ALLOC: begin
                            if (r_head == 8'd0) begin
                                fin_valid  = 1'b1;
                                fin_status = STS_EMPTY;
                            end else begin
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = r_head;
                                n_cur           = r_head;
                                n_state         = S_WALK;
                            end
                        end
                        F_FREE, F_READ: begin
                            if (!blk_ok) begin
                                fin_valid  = 1'b1;
                                fin_status = STS_RANGE;
                            end else begin
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = i_req.block;
                                n_cur           = i_req.block;
                                n_state         = S_WALK;
                            end
                        end
                        F_WRITE: begin
                            fin_valid = 1'b1;
                            if (!blk_ok) begin
                                fin_status = STS_RANGE;
                            end else begin
                                mem_req.wr_en   = 1'b1;
                                mem_req.wr_addr = i_req.block;
                                mem_req.wr_data = i_req.link_value;
                            end
                        end
                        F_COUNT: begin
                            if (r_head == 8'd0) begin
                                fin_valid = 1'b1;
                            end else begin
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = r_head;
                                n_cur           = r_head;
                                n_state         = S_WALK;
                            end
                        end
                        default: begin
                            fin_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_FMT: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = r_idx;
                mem_req.wr_data = fmt_last ? 8'd0 : r_idx + 8'd1;
                if (fmt_last) begin
                    n_head    = 8'(FIRST_BLOCK);
                    fin_valid = 1'b1;
                end else begin
                    n_idx = r_idx + 8'd1;
                end
            end
            S_WALK: begin
                case (r_func)
                    F_ALLOC: begin
                        n_head          = link;
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = r_cur;
                        mem_req.wr_data = 8'd0;
                        fin_valid       = 1'b1;
                        fin_bout        = r_cur;
                    end
                    F_READ: begin
                        fin_valid = 1'b1;
                        fin_bout  = link;
                    end
                    F_FREE: begin
                        if (link == 8'd0) begin
                            // tail found: splice the chain onto the list front
                            mem_req.wr_en   = 1'b1;
                            mem_req.wr_addr = r_cur;
                            mem_req.wr_data = r_head;
                            n_head          = r_blk;
                            fin_valid       = 1'b1;
                        end else if (r_steps <= {1'b0, eff_cnt}) begin
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = link;
                            n_cur           = link;
                            n_steps         = steps_inc;
                        end else begin
                            fin_valid  = 1'b1;
                            fin_status = STS_LOOP;
                        end
                    end
                    F_COUNT: begin
                        n_steps = steps_inc;
                        if (link != 8'd0 && steps_inc < {1'b0, eff_cnt}) begin
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = link;
                            n_cur           = link;
                        end else begin
                            fin_valid  = 1'b1;
                            fin_bytes  = (prod > 16'd4095) ? 12'hFFF : prod[11:0];
                            fin_status = (link != 8'd0) ? STS_LOOP : STS_OK;
                        end
                    end
                    default: begin
                        fin_valid = 1'b1;
                    end
                endcase
            end
            S_HOLD: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (fin_valid) begin
            n_state = slot_free ? S_IDLE : S_HOLD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= 8'd0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur   <= n_cur;
        r_steps <= n_steps;
        r_idx   <= n_idx;
        r_func  <= n_func;
        r_blk   <= n_blk;
    end

    // output word register, with a holding slot behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((fin_valid || r_state == S_HOLD) && slot_free) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_valid && slot_free) begin
            r_out_bout   <= fin_bout;
            r_out_bytes  <= fin_bytes;
            r_out_status <= fin_status;
        end else if (r_state == S_HOLD && slot_free) begin
            r_out_bout   <= r_hold_bout;
            r_out_bytes  <= r_hold_bytes;
            r_out_status <= r_hold_status;
        end
        if (fin_valid && !slot_free) begin
            r_hold_bout   <= fin_bout;
            r_hold_bytes  <= fin_bytes;
            r_hold_status <= fin_status;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.block_out  = r_out_bout;
    assign o_rsp.free_bytes = r_out_bytes;
    assign o_rsp.status     = r_out_status;

    // the walk state always consumes a table read issued in the previous cycle
    a_walk_has_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> $past(mem_req.rd_en))
        else $error("walk state without a pending table read");

    // a held word only exists while the output register is occupied
    a_hold_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HOLD) |-> r_out_valid)
        else $error("holding slot used while output register is empty");

    // the table never sees a read and a write of one entry together
    a_no_rw_same: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_req.rd_en && mem_req.wr_en && mem_req.rd_addr == mem_req.wr_addr))
        else $error("table read and write collide on one entry");

    // a finished result never lands while a word is already held
    a_no_double_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HOLD) |-> !fin_valid)
        else $error("new result while a held word is pending");

endmodule
